@@ rtl/cpu_exception_dispatch_core_macros.svh @@
// Assertion macros used by the checker file of the exception dispatch core.
// Depends on nothing; include by bare file name.
`ifndef CPU_EXCEPTION_DISPATCH_CORE_MACROS_SVH
`define CPU_EXCEPTION_DISPATCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define CED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

@@ rtl/ced_pkg.sv @@
// Types and constants of the exception dispatch core.
// Depends on nothing; used by ced_dispatch, the top level and the checker.
`default_nettype none
package ced_pkg;

  typedef enum logic [1:0] {
    CmdRaise    = 2'd0,
    CmdCheckAll = 2'd1,
    CmdCheckExt = 2'd2,
    CmdWriteMsr = 2'd3
  } cmd_e;

  localparam int unsigned NumExc = 10;

  // Dense pending-bit positions.
  localparam int unsigned ExcIsi   = 0;
  localparam int unsigned ExcProg  = 1;
  localparam int unsigned ExcSc    = 2;
  localparam int unsigned ExcFpu   = 3;
  localparam int unsigned ExcFake  = 4;
  localparam int unsigned ExcDsi   = 5;
  localparam int unsigned ExcAlign = 6;
  localparam int unsigned ExcExt   = 7;
  localparam int unsigned ExcPerf  = 8;
  localparam int unsigned ExcDec   = 9;

  localparam logic [31:0] SaveMask  = 32'h87C0_FFFF;
  localparam logic [31:0] ClearMask = 32'h0004_EF36;
  localparam logic [31:0] IsiFlag   = 32'h4000_0000;
  localparam int unsigned MsrLe  = 0;
  localparam int unsigned MsrEe  = 15;
  localparam int unsigned MsrIle = 16;

  localparam logic [11:0] VecIsi   = 12'h400;
  localparam logic [11:0] VecProg  = 12'h700;
  localparam logic [11:0] VecSc    = 12'hC00;
  localparam logic [11:0] VecFpu   = 12'h800;
  localparam logic [11:0] VecDsi   = 12'h300;
  localparam logic [11:0] VecAlign = 12'h600;
  localparam logic [11:0] VecExt   = 12'h500;
  localparam logic [11:0] VecPerf  = 12'hF00;
  localparam logic [11:0] VecDec   = 12'h900;

  typedef struct packed {
    cmd_e               command;
    logic [NumExc-1:0]  raise_mask;
    logic [31:0]        program_reason;
    logic [31:0]        current_pc;
    logic [31:0]        next_pc;
    logic [31:0]        new_status;
  } in_item_t;

  typedef struct packed {
    logic               taken;
    logic [11:0]        vector;
    logic [31:0]        target_pc;
    logic [31:0]        saved_pc;
    logic [31:0]        saved_status;
    logic [31:0]        status_word;
    logic [NumExc-1:0]  pending_out;
  } out_item_t;

  // Architectural state carried between items.
  typedef struct packed {
    logic [NumExc-1:0]  pending;
    logic [31:0]        status;
    logic [31:0]        save_pc;
    logic [31:0]        save_status;
  } arch_state_t;

endpackage
`default_nettype wire

@@ rtl/ced_dispatch.sv @@
// Combinational dispatch step: priority pick, state update and result build.
// Depends on ced_pkg.
`default_nettype none
module ced_dispatch (
  input  wire ced_pkg::in_item_t    item_i,
  input  wire ced_pkg::arch_state_t state_i,
  output ced_pkg::arch_state_t      state_o,
  output ced_pkg::out_item_t        result_o
);
  import ced_pkg::*;

  logic [31:0]       masked_msr;
  logic              ext_ok;
  logic              do_ext;
  logic              take;
  logic [11:0]       vec;
  logic [31:0]       pc_save;
  logic [31:0]       srr1;
  logic [NumExc-1:0] clr_bit;
  arch_state_t       nxt;
  logic [NumExc-1:0] pend;

  assign masked_msr = state_i.status & SaveMask;
  assign ext_ok     = state_i.status[MsrEe];
  assign pend       = state_i.pending;

  always_comb begin
    nxt     = state_i;
    take    = 1'b0;
    vec     = '0;
    pc_save = item_i.next_pc;
    srr1    = masked_msr;
    clr_bit = '0;
    do_ext  = 1'b0;

    case (item_i.command)
      CmdRaise: begin
        nxt.pending = pend | item_i.raise_mask;
        if (item_i.raise_mask[ExcProg]) begin
          nxt.save_status = item_i.program_reason;
        end
      end
      CmdCheckAll: begin
        if (pend[ExcIsi]) begin
          take = 1'b1; vec = VecIsi; srr1 = masked_msr | IsiFlag;
          clr_bit[ExcIsi] = 1'b1;
        end else if (pend[ExcProg]) begin
          take = 1'b1; vec = VecProg; pc_save = item_i.current_pc;
          srr1 = state_i.save_status | masked_msr;
          clr_bit[ExcProg] = 1'b1;
        end else if (pend[ExcSc]) begin
          take = 1'b1; vec = VecSc;
          clr_bit[ExcSc] = 1'b1;
        end else if (pend[ExcFpu]) begin
          take = 1'b1; vec = VecFpu; pc_save = item_i.current_pc;
          clr_bit[ExcFpu] = 1'b1;
        end else if (pend[ExcFake]) begin
          // Fake memcheck only drops itself and the dsi bit.
          nxt.pending[ExcFake] = 1'b0;
          nxt.pending[ExcDsi]  = 1'b0;
        end else if (pend[ExcDsi]) begin
          take = 1'b1; vec = VecDsi; pc_save = item_i.current_pc;
          clr_bit[ExcDsi] = 1'b1;
        end else if (pend[ExcAlign]) begin
          take = 1'b1; vec = VecAlign; pc_save = item_i.current_pc;
          clr_bit[ExcAlign] = 1'b1;
        end else begin
          do_ext = 1'b1;
        end
      end
      CmdCheckExt: begin
        do_ext = 1'b1;
      end
      CmdWriteMsr: begin
        nxt.status = item_i.new_status;
      end
      default: begin
        nxt = state_i;
      end
    endcase

    // Asynchronous sources, gated by EE.
    if (do_ext && ext_ok) begin
      if (pend[ExcExt]) begin
        take = 1'b1; vec = VecExt; clr_bit[ExcExt] = 1'b1;
      end else if (pend[ExcPerf]) begin
        take = 1'b1; vec = VecPerf; clr_bit[ExcPerf] = 1'b1;
      end else if (pend[ExcDec]) begin
        take = 1'b1; vec = VecDec; clr_bit[ExcDec] = 1'b1;
      end
    end

    if (take) begin
      nxt.save_pc     = pc_save;
      nxt.save_status = srr1;
      nxt.status      = state_i.status;
      nxt.status[MsrLe] = state_i.status[MsrIle];
      nxt.status      = nxt.status & ~ClearMask;
      nxt.pending     = pend & ~clr_bit;
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.taken        = take;
    result_o.vector       = vec;
    result_o.target_pc    = take ? {20'd0, vec} : item_i.current_pc;
    result_o.saved_pc     = nxt.save_pc;
    result_o.saved_status = nxt.save_status;
    result_o.status_word  = nxt.status;
    result_o.pending_out  = nxt.pending;
  end

endmodule
`default_nettype wire

@@ rtl/cpu_exception_dispatch_core.sv @@
// Top level of the exception dispatch core: input register, dispatch step,
// result register and the architectural state. Depends on ced_pkg, ced_dispatch.
//
// One command item in, one result item out. An accepted item sits in the
// input register; the dispatch step then updates the pending mask, status
// word and both save registers and loads the result register, and an item
// may be accepted every cycle as long as results are taken. The rate is set
// by the single registered pass through the priority pick and state update;
// each item reads the state the previous item left, which is updated in the
// same edge that loads its result. The input register refills while a result
// waits, so a stall on the output side blocks input only once both registers
// hold items. Reset clears the pending mask, status word and save registers
// to zero.
`default_nettype none
module cpu_exception_dispatch_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire ced_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output ced_pkg::out_item_t       out_item_o
);
  import ced_pkg::*;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q;
  arch_state_t state_q;
  arch_state_t state_d;
  out_item_t   result_d;
  logic        advance;

  // Advance the held item when the result slot is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  ced_dispatch u_dispatch (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

@@ rtl/ced_checker.sv @@
// Port-level checker for the exception dispatch core, bound to the top level.
// Depends on ced_pkg and cpu_exception_dispatch_core_macros.svh.
`default_nettype none
`include "cpu_exception_dispatch_core_macros.svh"
module ced_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_o,
  input wire ced_pkg::in_item_t   in_item_i,
  input wire                      out_valid_o,
  input wire                      out_ready_i,
  input wire ced_pkg::out_item_t  out_item_o
);
  import ced_pkg::*;

  // A waiting input item holds.
  `CED_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_item_i))
  // A stalled result holds.
  `CED_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  // A taken exception jumps to its nonzero vector.
  `CED_ASSERT_IMP(a_taken_target, clk_i, rst_ni, out_valid_o && out_item_o.taken, out_item_o.vector != 12'd0 && out_item_o.target_pc == {20'd0, out_item_o.vector})
  // No vector without a taken exception.
  `CED_ASSERT_IMP(a_idle_vector, clk_i, rst_ni, out_valid_o && !out_item_o.taken, out_item_o.vector == 12'd0)
  // Handler entry leaves the cleared status bits low.
  `CED_ASSERT_IMP(a_taken_clear, clk_i, rst_ni, out_valid_o && out_item_o.taken, (out_item_o.status_word & ClearMask) == 32'd0)

endmodule

bind cpu_exception_dispatch_core ced_checker u_ced_checker (.*);
`default_nettype wire
